[rtl/tsr_pkg.sv]
package tsr_pkg;

    // Default table size and fixed field widths.
    localparam int SLOT_COUNT_DEF = 16;
    localparam int ID_W           = 32;
    localparam int SLOT_OUT_W     = 4;

    // Result packing: slot_index, was_hit, evicted_valid, evicted_id, then zero fill.
    localparam int OUT_FIELDS_W = SLOT_OUT_W + 2 + ID_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the incoming texture id
        logic compare;  // match the id against every slot
        logic update;   // apply replacement and load the result register
    } t_dp_cmd;

endpackage

[rtl/tsr_ctrl.sv]
module tsr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output tsr_pkg::t_dp_cmd o_cmd
);
    import tsr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_accept;
    logic       w_out_free;

    assign w_accept   = i_s_axis_tvalid && (r_state == S_IDLE);
    // The result register can take a new item when empty or being drained.
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid && !i_m_axis_tready;
        o_cmd.load    = 1'b0;
        o_cmd.compare = 1'b0;
        o_cmd.update  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.compare = 1'b1;
                n_state       = S_UPD;
            end
            S_UPD: begin
                if (w_out_free) begin
                    o_cmd.update = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;

endmodule

[rtl/tsr_dpath.sv]
module tsr_dpath #(
    parameter int SLOT_COUNT = tsr_pkg::SLOT_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tsr_pkg::t_dp_cmd                i_cmd,
    input  logic [tsr_pkg::ID_W-1:0]        i_texture_id,
    output logic [tsr_pkg::OUT_TDATA_W-1:0] o_result
);
    import tsr_pkg::*;

    localparam int SW = $clog2(SLOT_COUNT);

    logic [ID_W-1:0]       r_id;
    logic [ID_W-1:0]       r_resident [SLOT_COUNT];
    logic [SW-1:0]         r_order    [SLOT_COUNT];
    logic [SW-1:0]         n_order    [SLOT_COUNT];
    logic                  r_hit;
    logic [SW-1:0]         r_slot;
    logic                  n_hit;
    logic [SW-1:0]         n_slot;
    logic [SW-1:0]         w_victim;
    logic [ID_W-1:0]       w_old;
    logic                  w_zero;
    logic [SLOT_OUT_W-1:0] r_out_slot;
    logic                  r_out_hit;
    logic                  r_out_ev_valid;
    logic [ID_W-1:0]       r_out_ev_id;

    assign w_zero   = (r_id == '0);
    assign w_victim = r_order[SLOT_COUNT-1];
    assign w_old    = r_resident[w_victim];

    // Lowest matching slot; resident ids are unique, so at most one matches.
    always_comb begin
        n_hit  = 1'b0;
        n_slot = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (r_resident[i] == r_id) begin
                n_hit  = 1'b1;
                n_slot = SW'(i);
            end
        end
        if (w_zero) begin
            n_hit = 1'b0;
        end
    end

    // Next priority order: one-place swap on a hit, move-to-front on a miss.
    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            n_order[i] = r_order[i];
            if (r_hit) begin
                if (i + 1 < SLOT_COUNT && r_order[(i + 1) % SLOT_COUNT] == r_slot) begin
                    n_order[i] = r_slot;
                end else if (i > 0 && r_order[i] == r_slot) begin
                    n_order[i] = r_order[(i + SLOT_COUNT - 1) % SLOT_COUNT];
                end
            end else if (i == 0) begin
                n_order[i] = w_victim;
            end else begin
                n_order[i] = r_order[(i + SLOT_COUNT - 1) % SLOT_COUNT];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_id <= i_texture_id;
        end
        if (i_cmd.compare) begin
            r_hit  <= n_hit;
            r_slot <= n_slot;
        end
        if (i_cmd.update) begin
            if (w_zero) begin
                r_out_slot     <= '0;
                r_out_hit      <= 1'b0;
                r_out_ev_valid <= 1'b0;
                r_out_ev_id    <= '0;
            end else if (r_hit) begin
                r_out_slot     <= SLOT_OUT_W'(r_slot);
                r_out_hit      <= 1'b1;
                r_out_ev_valid <= 1'b0;
                r_out_ev_id    <= '0;
            end else begin
                r_out_slot     <= SLOT_OUT_W'(w_victim);
                r_out_hit      <= 1'b0;
                r_out_ev_valid <= (w_old != '0);
                r_out_ev_id    <= w_old;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_resident[i] <= '0;
                r_order[i]    <= SW'(i);
            end
        end else if (i_cmd.update && !w_zero) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_order[i] <= n_order[i];
            end
            if (!r_hit) begin
                r_resident[w_victim] <= r_id;
            end
        end
    end

    assign o_result = OUT_TDATA_W'({r_out_ev_id, r_out_ev_valid, r_out_hit, r_out_slot});

endmodule

[rtl/texture_slot_replacement.sv]
// Each accepted item passes through capture, parallel tag compare and replacement
// update before its result is presented; a new item is taken only once the last
// has finished its update, and the update step waits only while a result is still untaken.
// Reset (synchronous, active low): every slot is empty and the priority order
// runs from slot 0 first to the last slot last; no result is pending.
module texture_slot_replacement #(
    parameter int SLOT_COUNT = tsr_pkg::SLOT_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input stream. tdata: [31:0] texture_id.
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [tsr_pkg::ID_W-1:0]        i_s_axis_tdata,
    // Result stream. tdata: [3:0] slot_index, [4] was_hit, [5] evicted_valid,
    // [37:6] evicted_id, [39:38] zero.
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [tsr_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import tsr_pkg::*;

    // Commands from the sequencer into the slot table datapath.
    t_dp_cmd w_cmd;

    // The controller steps each item through capture, compare and update, and
    // owns the valid flag of the result register.
    tsr_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_cmd           (w_cmd)
    );

    // The datapath holds the resident ids, the priority order and the result
    // payload register.
    tsr_dpath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_texture_id (i_s_axis_tdata),
        .o_result     (o_m_axis_tdata)
    );

    // The block works on one item at a time, so it is busy right after an accept.
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready
    ) else $error("input accepted while an item was in flight");

    // A hit never reports an eviction.
    a_hit_no_evict: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[4])
            |-> (!o_m_axis_tdata[5] && o_m_axis_tdata[37:6] == '0)
    ) else $error("hit result carries an eviction");

    // The eviction flag agrees with the evicted id being nonzero.
    a_evict_flag: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[5] == (o_m_axis_tdata[37:6] != '0))
    ) else $error("eviction flag disagrees with evicted id");

endmodule

[test/tb_texture_slot_replacement.sv]
`timescale 1ns / 1ps

module tb_texture_slot_replacement;

    import tsr_pkg::*;

    localparam int SLOTS       = SLOT_COUNT_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int POOL_SIZE   = 24;    // a few more ids than slots: hits and evictions mix
    localparam int RANDOM_ITEMS = 1300;

    // One result item as it sits in the result tdata, lowest field last.
    typedef struct packed {
        logic [1:0]        fill;
        logic [ID_W-1:0]   evicted_id;
        logic              evicted_valid;
        logic              was_hit;
        logic [SLOT_OUT_W-1:0] slot_index;
    } t_binding;

    // Tracks the slot table and the replacement order, and holds the bindings
    // that the block still owes us, oldest first.
    class slot_binding_tracker;
        logic [ID_W-1:0]       resident [SLOTS];
        logic [SLOT_OUT_W-1:0] rank [SLOTS];    // rank[0] is the slot in first place
        t_binding              pending_bindings [$];
        int                    failures;

        function new();
            for (int s = 0; s < SLOTS; s++) begin
                resident[s] = '0;
                rank[s]     = SLOT_OUT_W'(s);
            end
            failures = 0;
        endfunction

        function void flag(string what);
            failures++;
            if (failures <= 10) begin
                $display("[%0t] ERROR: %s", $time, what);
            end
        endfunction

        // Called for every accepted texture id.
        function void note_bind(logic [ID_W-1:0] id);
            t_binding              b;
            int                    hit_slot;
            logic [SLOT_OUT_W-1:0] victim;
            b = '0;
            // The empty marker is never looked up; the table is left alone.
            if (id != '0) begin
                hit_slot = -1;
                for (int s = 0; s < SLOTS; s++) begin
                    if (hit_slot < 0 && resident[s] == id) hit_slot = s;
                end
                if (hit_slot >= 0) begin
                    b.slot_index = SLOT_OUT_W'(hit_slot);
                    b.was_hit    = 1'b1;
                    // Swap one place toward the front, unless already first.
                    for (int p = 1; p < SLOTS; p++) begin
                        if (rank[p] == SLOT_OUT_W'(hit_slot)) begin
                            rank[p]     = rank[p-1];
                            rank[p-1]   = SLOT_OUT_W'(hit_slot);
                            break;
                        end
                    end
                end else begin
                    victim          = rank[SLOTS-1];
                    b.slot_index    = victim;
                    b.evicted_id    = resident[victim];
                    b.evicted_valid = (resident[victim] != '0);
                    resident[victim] = id;
                    for (int p = SLOTS - 1; p > 0; p--) rank[p] = rank[p-1];
                    rank[0] = victim;
                end
            end
            pending_bindings.push_back(b);
        endfunction

        // Called for every accepted result item.
        function void check_binding(logic [OUT_TDATA_W-1:0] data);
            t_binding got;
            t_binding want;
            got = data;
            if (pending_bindings.size() == 0) begin
                flag($sformatf("result with nothing outstanding: %h", data));
                return;
            end
            want = pending_bindings.pop_front();
            if (got.slot_index !== want.slot_index || got.was_hit !== want.was_hit ||
                got.evicted_valid !== want.evicted_valid ||
                got.evicted_id !== want.evicted_id || got.fill !== want.fill) begin
                flag($sformatf({"binding mismatch: expected slot %0d hit %0b ev %0b id %h",
                                " fill %b, got slot %0d hit %b ev %b id %h fill %b"},
                               want.slot_index, want.was_hit, want.evicted_valid,
                               want.evicted_id, want.fill, got.slot_index, got.was_hit,
                               got.evicted_valid, got.evicted_id, got.fill));
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic [ID_W-1:0]        s_tdata = '0;
    logic                   m_tready = 1'b0;
    logic                   s_tready;
    logic                   m_tvalid;
    logic [OUT_TDATA_W-1:0] m_tdata;

    slot_binding_tracker binding_tracker;
    int                  items_sent = 0;
    int                  results_taken = 0;
    int                  rx_hold = 0;
    int                  cycle_count = 0;
    logic [ID_W-1:0]     id_pool [POOL_SIZE];

    texture_slot_replacement uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),    // [31:0] texture_id
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)     // [3:0] slot, [4] hit, [5] ev valid, [37:6] ev id
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side. Outside every other stretch of 64 results, where the port stays
    // ready, a result item is followed by a random stall nine times in ten.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            rx_hold  <= 0;
        end else if (m_tready && m_tvalid) begin
            binding_tracker.check_binding(m_tdata);
            results_taken <= results_taken + 1;
            if (results_taken % 128 < 64 || $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                rx_hold  <= $urandom_range(1, 9);
            end
        end else if (!m_tready) begin
            if (rx_hold <= 1) begin
                m_tready <= 1'b1;
            end else begin
                rx_hold <= rx_hold - 1;
            end
        end
    end

    // Offers one texture id and returns once it has been accepted. The valid
    // stays up when the next item follows without a gap, so it is never
    // dropped and raised within one time step.
    task automatic send_texture(input logic [ID_W-1:0] id);
        int gap;
        gap = (items_sent % 128 < 40) ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= id;
        do @(posedge i_clk); while (!s_tready);
        binding_tracker.note_bind(id);
        items_sent++;
    endtask

    initial begin
        int              pick;
        logic [ID_W-1:0] id;

        binding_tracker = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: the empty marker, field extremes, a full table of
        // misses into empty slots, hits in first and last place, an eviction.
        send_texture('0);
        send_texture(32'hFFFF_FFFF);
        send_texture(32'h0000_0001);
        send_texture(32'hAAAA_AAAA);
        send_texture(32'h5555_5555);
        send_texture(32'h8000_0000);
        send_texture(32'h7FFF_FFFF);
        for (int k = 0; k < 10; k++) send_texture(32'h0000_0100 + k);
        send_texture(32'h0000_0109);    // newest fill, so already first
        send_texture(32'hFFFF_FFFF);    // oldest fill, moves up from last place
        send_texture('0);               // empty marker against a full table
        send_texture(32'hDEAD_BEEF);    // miss that displaces a resident id
        send_texture(32'h0000_0001);
        send_texture(32'hDEAD_BEEF);

        // Random part. Most ids come from a working set a little larger than
        // the table, so hits land at every rank and evictions keep happening;
        // the rest are fresh random ids and the empty marker.
        for (int p = 0; p < POOL_SIZE; p++) begin
            id_pool[p] = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(1, 64);
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                id = '0;
            end else if (pick < 80) begin
                id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
            end else if (pick < 90) begin
                id = $urandom;
                id_pool[$urandom_range(0, POOL_SIZE - 1)] = id;
            end else begin
                id = $urandom;
            end
            send_texture(id);
        end
        s_tvalid <= 1'b0;

        // Drain, then keep watching for anything the block should not send.
        while (binding_tracker.pending_bindings.size() > 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        if (binding_tracker.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/tsr_pkg.sv
rtl/tsr_ctrl.sv
rtl/tsr_dpath.sv
rtl/texture_slot_replacement.sv
test/tb_texture_slot_replacement.sv
